@@ design/tce_pkg.sv @@
`timescale 1ns / 1ps

package tce_pkg;

    // Storage sizes
    localparam int DATA_DEPTH  = 256;
    localparam int STACK_DEPTH = 128;
    localparam int DATA_AW     = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W        = $clog2(STACK_DEPTH) + 1;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int CMD_W    = 4;
    localparam int MODE_W   = 3;
    localparam int DOP_W    = 31;
    localparam int STATUS_W = 3;
    localparam int CODE_W   = 11;
    localparam int DLEN_W   = 9;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_MOV  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_CMP  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_JMP  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_JZ   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_JNZ  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_HALT = 4'd6;
    localparam logic [CMD_W-1:0] CMD_PUSH = 4'd7;
    localparam logic [CMD_W-1:0] CMD_POP  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_LOAD = 4'd9;

    // Operand modes
    localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IMM  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REG  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIR  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_IND  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OPERAND   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDRESS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_LENGTH = 1'b1;

    localparam logic [WORD_W-1:0] REG_IDX_MAX = 32'd3;

    typedef logic [WORD_W-1:0]         t_word;
    typedef logic [3:0][WORD_W-1:0]    t_regs;
    typedef logic [DATA_AW-1:0]        t_daddr;
    typedef logic [STACK_AW-1:0]       t_saddr;
    typedef logic signed [SP_W-1:0]    t_sp;

    localparam t_sp SP_TOP = t_sp'(STACK_DEPTH - 1);

    typedef enum logic [1:0] {
        K_NONE,
        K_IMM,
        K_REG,
        K_MEM
    } t_kind;

    // Resolved operand
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_kind               kind;
        logic [1:0]          idx;
        t_daddr              addr;
        t_word               imm;
    } t_opnd;

    // Captured input transaction
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [MODE_W-1:0] dmode;
        logic [DOP_W-1:0]  dop;
        logic [MODE_W-1:0] smode;
        t_word             sop;
    } t_item;

    // Execute stage payload
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [STATUS_W-1:0] status;
        t_opnd               d;
        t_opnd               s;
    } t_s2;

    // Memory read request, issued on the stage advance
    typedef struct packed {
        logic   en;
        t_daddr d_addr;
        t_daddr s_addr;
        t_saddr stk_addr;
    } t_rd_req;

    typedef struct packed {
        logic   en;
        t_daddr addr;
        t_word  data;
    } t_dmem_wr;

    typedef struct packed {
        logic   en;
        t_saddr addr;
        t_word  data;
    } t_stk_wr;

    function automatic logic addr_ok(input t_word a, input logic [DLEN_W-1:0] dlen);
        return (a < WORD_W'(dlen)) && (a < WORD_W'(DATA_DEPTH));
    endfunction

endpackage

@@ design/tce_cmd_if.sv @@
`timescale 1ns / 1ps

interface tce_cmd_if;
    logic              valid;
    logic              ready;
    logic [3:0]        command;
    logic [2:0]        dest_mode;
    logic [30:0]       dest_operand;
    logic [2:0]        src_mode;
    logic signed [31:0] src_operand;

    modport source (
        output valid, command, dest_mode, dest_operand, src_mode, src_operand,
        input  ready
    );
    modport sink (
        input  valid, command, dest_mode, dest_operand, src_mode, src_operand,
        output ready
    );
endinterface

@@ design/tce_res_if.sv @@
`timescale 1ns / 1ps

interface tce_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] next_ip;
    logic               zero_flag;
    logic               sign_flag;
    logic signed [31:0] written_value;

    modport source (
        output valid, status, next_ip, zero_flag, sign_flag, written_value,
        input  ready
    );
    modport sink (
        input  valid, status, next_ip, zero_flag, sign_flag, written_value,
        output ready
    );
endinterface

@@ design/toy_cpu_execute_unit_core.sv @@
`timescale 1ns / 1ps

// Channel    Dir  Modport  Handshake      Payload
// i_cmd_if   in   sink     valid/ready    command, dest/src mode and operand
// o_res_if   out  source   valid/ready    status, next_ip, flags, written_value
// i_cfg_*    in   -        write enable   code_length (0), data_length (1)
//
// Each instruction passes operand resolution with the data/stack memory
// read (registered RAM port), then execute and write-back into the result
// register. A new transaction is taken whenever the operand stage is empty,
// also while a result waits; a stalled result holds the execute stage.
// Reset is synchronous: clears valid bits, registers, pointer, flags, stack
// pointer and config; data and stack memories are not cleared.

module toy_cpu_execute_unit_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tce_cmd_if.sink                       i_cmd_if,
    tce_res_if.source                     o_res_if,
    input  logic                          i_cfg_we,
    input  logic [tce_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tce_pkg::CFG_W-1:0]     i_cfg_data
);
    import tce_pkg::*;

    logic [CODE_W-1:0] r_code_length;
    logic [DLEN_W-1:0] r_data_length;

    t_regs    regs;
    t_sp      sp;
    logic     s2_valid;
    t_s2      s2;
    logic     s2_done;
    t_rd_req  rd_req;
    t_dmem_wr dmem_wr;
    t_stk_wr  stk_wr;
    t_word    dmem_d;
    t_word    dmem_s;
    t_word    stk_rd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_length <= '0;
            r_data_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CODE_LENGTH: r_code_length <= i_cfg_data[CODE_W-1:0];
                CFG_DATA_LENGTH: r_data_length <= i_cfg_data[DLEN_W-1:0];
            endcase
        end
    end

    // Operand stage
    tce_operand u_operand (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_if     (i_cmd_if),
        .i_regs       (regs),
        .i_sp         (sp),
        .i_data_length(r_data_length),
        .i_s2_done    (s2_done),
        .o_s2_valid   (s2_valid),
        .o_s2         (s2),
        .o_rd_req     (rd_req)
    );

    // Data memory, one copy per read port
    tce_ram #(.DEPTH(DATA_DEPTH), .WIDTH(WORD_W)) u_dmem_d (
        .i_clk  (i_clk),
        .i_we   (dmem_wr.en),
        .i_waddr(dmem_wr.addr),
        .i_wdata(dmem_wr.data),
        .i_re   (rd_req.en),
        .i_raddr(rd_req.d_addr),
        .o_rdata(dmem_d)
    );

    tce_ram #(.DEPTH(DATA_DEPTH), .WIDTH(WORD_W)) u_dmem_s (
        .i_clk  (i_clk),
        .i_we   (dmem_wr.en),
        .i_waddr(dmem_wr.addr),
        .i_wdata(dmem_wr.data),
        .i_re   (rd_req.en),
        .i_raddr(rd_req.s_addr),
        .o_rdata(dmem_s)
    );

    // Stack memory
    tce_ram #(.DEPTH(STACK_DEPTH), .WIDTH(WORD_W)) u_stack (
        .i_clk  (i_clk),
        .i_we   (stk_wr.en),
        .i_waddr(stk_wr.addr),
        .i_wdata(stk_wr.data),
        .i_re   (rd_req.en),
        .i_raddr(rd_req.stk_addr),
        .o_rdata(stk_rd)
    );

    // Execute stage and result register
    tce_execute u_execute (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s2_valid   (s2_valid),
        .i_s2         (s2),
        .i_dmem_d     (dmem_d),
        .i_dmem_s     (dmem_s),
        .i_stk_rd     (stk_rd),
        .i_code_length(r_code_length),
        .o_s2_done    (s2_done),
        .o_regs       (regs),
        .o_sp         (sp),
        .o_dmem_wr    (dmem_wr),
        .o_stk_wr     (stk_wr),
        .o_res_if     (o_res_if)
    );

endmodule

@@ design/tce_ram.sv @@
`timescale 1ns / 1ps

module tce_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/tce_operand.sv @@
`timescale 1ns / 1ps

module tce_operand (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    tce_cmd_if.sink                   i_cmd_if,
    input  tce_pkg::t_regs            i_regs,
    input  tce_pkg::t_sp              i_sp,
    input  logic [tce_pkg::DLEN_W-1:0] i_data_length,
    input  logic                      i_s2_done,
    output logic                      o_s2_valid,
    output tce_pkg::t_s2              o_s2,
    output tce_pkg::t_rd_req          o_rd_req
);
    import tce_pkg::*;

    logic  r_s1_valid;
    t_item r_s1;
    logic  r_s2_valid;
    t_s2   r_s2;

    logic  accept;
    logic  advance;
    t_opnd d_res;
    t_opnd s_res;
    t_s2   n_s2;
    t_sp   sp_inc;

    // Operand resolution: register check, address fetch and bounds check
    function automatic t_opnd resolve(
        input logic [MODE_W-1:0]  mode,
        input t_word              opnd,
        input t_regs              regs,
        input logic [DLEN_W-1:0]  dlen
    );
        t_opnd o;
        t_word a;
        logic  use_a;
        o.status = ST_OK;
        o.kind   = K_NONE;
        o.idx    = opnd[1:0];
        o.addr   = '0;
        o.imm    = opnd;
        a        = opnd;
        use_a    = 1'b0;
        unique case (mode)
            MODE_NONE: begin
            end
            MODE_IMM: begin
                o.kind = K_IMM;
            end
            MODE_REG: begin
                if (opnd > REG_IDX_MAX) o.status = ST_OPERAND;
                else                    o.kind   = K_REG;
            end
            MODE_DIR: begin
                use_a = 1'b1;
            end
            MODE_IND: begin
                if (opnd > REG_IDX_MAX) begin
                    o.status = ST_OPERAND;
                end else begin
                    a     = regs[opnd[1:0]];
                    use_a = 1'b1;
                end
            end
            default: begin
                o.status = ST_OPERAND;
            end
        endcase
        if (use_a) begin
            if (addr_ok(a, dlen)) begin
                o.kind = K_MEM;
                o.addr = a[DATA_AW-1:0];
            end else begin
                o.status = ST_ADDRESS;
            end
        end
        return o;
    endfunction

    // Handshake: one transaction held in the operand stage
    assign i_cmd_if.ready = !r_s1_valid;
    assign accept  = i_cmd_if.valid && !r_s1_valid;
    assign advance = r_s1_valid && !r_s2_valid;

    // Resolve both operands against the current architectural state
    always_comb begin
        d_res = resolve(r_s1.dmode, {1'b0, r_s1.dop}, i_regs, i_data_length);
        s_res = resolve(r_s1.smode, r_s1.sop, i_regs, i_data_length);
        n_s2.cmd = r_s1.cmd;
        n_s2.d   = d_res;
        n_s2.s   = s_res;
        if (r_s1.cmd == CMD_LOAD) begin
            // data load: dest is the address, modes are ignored
            n_s2.d.kind = K_MEM;
            n_s2.d.addr = r_s1.dop[DATA_AW-1:0];
            n_s2.status = addr_ok({1'b0, r_s1.dop}, i_data_length) ? ST_OK : ST_ADDRESS;
        end else if (r_s1.cmd > CMD_LOAD) begin
            n_s2.status = ST_UNKNOWN;
        end else if (d_res.status != ST_OK) begin
            n_s2.status = d_res.status;
        end else begin
            n_s2.status = s_res.status;
        end
    end

    // Memory reads launch on the advance edge
    assign sp_inc = i_sp + t_sp'(1);
    always_comb begin
        o_rd_req.en       = advance;
        o_rd_req.d_addr   = n_s2.d.addr;
        o_rd_req.s_addr   = n_s2.s.addr;
        o_rd_req.stk_addr = sp_inc[STACK_AW-1:0];
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept)       r_s1_valid <= 1'b1;
            else if (advance) r_s1_valid <= 1'b0;
            if (advance)        r_s2_valid <= 1'b1;
            else if (i_s2_done) r_s2_valid <= 1'b0;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.cmd   <= i_cmd_if.command;
            r_s1.dmode <= i_cmd_if.dest_mode;
            r_s1.dop   <= i_cmd_if.dest_operand;
            r_s1.smode <= i_cmd_if.src_mode;
            r_s1.sop   <= i_cmd_if.src_operand;
        end
        if (advance) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2_valid = r_s2_valid;
    assign o_s2       = r_s2;

    // An advance empties the operand stage and fills the execute stage
    a_advance_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_s2_valid && !r_s1_valid))
        else $error("operand stage advance did not move the transaction");

    // No completion while the execute stage is empty
    a_done_needs_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s2_done |-> r_s2_valid)
        else $error("execute completion without a transaction");

endmodule

@@ design/tce_execute.sv @@
`timescale 1ns / 1ps

module tce_execute (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s2_valid,
    input  tce_pkg::t_s2               i_s2,
    input  tce_pkg::t_word             i_dmem_d,
    input  tce_pkg::t_word             i_dmem_s,
    input  tce_pkg::t_word             i_stk_rd,
    input  logic [tce_pkg::CODE_W-1:0] i_code_length,
    output logic                       o_s2_done,
    output tce_pkg::t_regs             o_regs,
    output tce_pkg::t_sp               o_sp,
    output tce_pkg::t_dmem_wr          o_dmem_wr,
    output tce_pkg::t_stk_wr           o_stk_wr,
    tce_res_if.source                  o_res_if
);
    import tce_pkg::*;

    // Architectural state
    t_regs r_regs;
    t_word r_ip;
    logic  r_zero;
    logic  r_sign;
    t_sp   r_sp;

    // Output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    t_word               r_nip;
    logic                r_zf;
    logic                r_sf;
    t_word               r_wv;

    logic                s2_done;
    t_word               d_val;
    t_word               s_val;
    t_word               sum;
    t_word               diff;
    t_word               push_val;
    logic                both;
    logic                hasd;
    logic                wr_go;
    t_word               wr_val;
    logic [STATUS_W-1:0] n_status;
    t_word               n_wv;
    t_word               n_nip;
    t_regs               n_regs;
    logic                n_zero;
    logic                n_sign;
    t_sp                 n_sp;
    t_dmem_wr            dwr;
    t_stk_wr             swr;

    assign s2_done = i_s2_valid && (!r_out_valid || o_res_if.ready);

    // Operand values
    always_comb begin
        unique case (i_s2.d.kind)
            K_NONE: d_val = '0;
            K_IMM:  d_val = i_s2.d.imm;
            K_REG:  d_val = r_regs[i_s2.d.idx];
            K_MEM:  d_val = i_dmem_d;
        endcase
        unique case (i_s2.s.kind)
            K_NONE: s_val = '0;
            K_IMM:  s_val = i_s2.s.imm;
            K_REG:  s_val = r_regs[i_s2.s.idx];
            K_MEM:  s_val = i_dmem_s;
        endcase
    end

    assign sum      = d_val + s_val;
    assign diff     = d_val - s_val;
    assign push_val = (i_s2.s.kind != K_NONE) ? s_val : r_regs[0];
    assign both     = (i_s2.d.kind != K_NONE) && (i_s2.s.kind != K_NONE);
    assign hasd     = i_s2.d.kind != K_NONE;

    // Command execution
    always_comb begin
        n_status = i_s2.status;
        n_wv     = '0;
        n_nip    = r_ip + 32'd1;
        n_regs   = r_regs;
        n_zero   = r_zero;
        n_sign   = r_sign;
        n_sp     = r_sp;
        wr_go    = 1'b0;
        wr_val   = '0;
        dwr.en   = 1'b0;
        dwr.addr = i_s2.d.addr;
        dwr.data = '0;
        swr.en   = 1'b0;
        swr.addr = r_sp[STACK_AW-1:0];
        swr.data = push_val;

        if (i_s2.cmd == CMD_LOAD) begin
            n_nip = r_ip;
            if (i_s2.status == ST_OK) begin
                dwr.en   = 1'b1;
                dwr.data = i_s2.s.imm;
                n_wv     = i_s2.s.imm;
            end
        end else if (i_s2.status == ST_OK) begin
            unique case (i_s2.cmd)
                CMD_MOV: begin
                    if (!both) begin
                        n_status = ST_OPERAND;
                    end else begin
                        wr_go  = 1'b1;
                        wr_val = s_val;
                        n_wv   = s_val;
                    end
                end
                CMD_ADD: begin
                    if (!both) begin
                        n_status = ST_OPERAND;
                    end else begin
                        wr_go  = 1'b1;
                        wr_val = sum;
                        n_wv   = sum;
                    end
                end
                CMD_CMP: begin
                    if (!both) begin
                        n_status = ST_OPERAND;
                    end else begin
                        n_zero = (diff == '0);
                        n_sign = diff[WORD_W-1];
                    end
                end
                CMD_JMP, CMD_JZ, CMD_JNZ: begin
                    if (!hasd) begin
                        n_status = ST_OPERAND;
                    end else if ((i_s2.cmd == CMD_JMP) ||
                                 ((i_s2.cmd == CMD_JZ) && r_zero) ||
                                 ((i_s2.cmd == CMD_JNZ) && !r_zero)) begin
                        n_nip = d_val;
                    end
                end
                CMD_HALT: begin
                    n_nip = WORD_W'(i_code_length);
                end
                CMD_PUSH: begin
                    if (r_sp[SP_W-1]) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        swr.en = 1'b1;
                        n_sp   = r_sp - t_sp'(1);
                        n_wv   = push_val;
                    end
                end
                CMD_POP: begin
                    if (r_sp == SP_TOP) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_sp = r_sp + t_sp'(1);
                        n_wv = i_stk_rd;
                        if (hasd) begin
                            wr_go  = 1'b1;
                            wr_val = i_stk_rd;
                        end else begin
                            n_regs[0] = i_stk_rd;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // Destination write; an immediate destination takes no write
        if (wr_go) begin
            if (i_s2.d.kind == K_REG) begin
                n_regs[i_s2.d.idx] = wr_val;
            end else if (i_s2.d.kind == K_MEM) begin
                dwr.en   = 1'b1;
                dwr.data = wr_val;
            end
        end
    end

    // Memory writes only on completion
    always_comb begin
        o_dmem_wr    = dwr;
        o_dmem_wr.en = dwr.en && s2_done;
        o_stk_wr     = swr;
        o_stk_wr.en  = swr.en && s2_done;
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
            r_ip   <= '0;
            r_zero <= 1'b0;
            r_sign <= 1'b0;
            r_sp   <= SP_TOP;
        end else if (s2_done) begin
            r_regs <= n_regs;
            r_ip   <= n_nip;
            r_zero <= n_zero;
            r_sign <= n_sign;
            r_sp   <= n_sp;
        end
    end

    // Result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_done) begin
            r_out_valid <= 1'b1;
        end else if (o_res_if.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_done) begin
            r_status <= n_status;
            r_nip    <= n_nip;
            r_zf     <= n_zero;
            r_sf     <= n_sign;
            r_wv     <= (n_status == ST_OK) ? n_wv : '0;
        end
    end

    assign o_res_if.valid         = r_out_valid;
    assign o_res_if.status        = r_status;
    assign o_res_if.next_ip       = r_nip;
    assign o_res_if.zero_flag     = r_zf;
    assign o_res_if.sign_flag     = r_sf;
    assign o_res_if.written_value = r_wv;

    assign o_s2_done = s2_done;
    assign o_regs    = r_regs;
    assign o_sp      = r_sp;

    // Stack pointer stays within -1 .. depth-1
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_sp[SP_W-1] || (r_sp == '1)) && (r_sp <= SP_TOP))
        else $error("stack pointer out of range");

    // Architectural state only moves on a completion
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s2_done |=> ($stable(r_regs) && $stable(r_ip) && $stable(r_sp)))
        else $error("state changed without a completion");

    // A failed instruction reports no written value
    a_err_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_done && (n_status != ST_OK)) |=> (r_wv == '0))
        else $error("nonzero written value on error status");

endmodule

@@ bench/toy_cpu_execute_unit_core_tb.sv @@
`timescale 1ns / 1ps

module toy_cpu_execute_unit_core_tb;
    import tce_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_PRINTED  = 50;

    // Codes outside the defined command and mode sets
    localparam logic [CMD_W-1:0]  CMD_UNKNOWN_LO = 4'd10;
    localparam logic [CMD_W-1:0]  CMD_UNKNOWN_HI = 4'd15;
    localparam logic [MODE_W-1:0] MODE_BAD_LO    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BAD_HI    = 3'd7;

    // General register indexes
    localparam t_word REG_AX = 32'd0;
    localparam t_word REG_BX = 32'd1;
    localparam t_word REG_CX = 32'd2;
    localparam t_word REG_DX = 32'd3;
    localparam t_word REG_BAD = 32'd4;

    // Outcome of one retired instruction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_word               next_ip;
        logic                zf;
        logic                sf;
        t_word               wv;
    } retire_t;

    // Architectural shadow of the execute unit: predicts and checks outcomes
    class cpu_shadow;
        t_word             gpr [4];
        t_word             pc;
        logic              zf;
        logic              sf;
        int                sp;
        t_word             dmem [DATA_DEPTH];
        t_word             stk [STACK_DEPTH];
        logic [CODE_W-1:0] code_len;
        logic [DLEN_W-1:0] data_len;
        retire_t           outcomes_due [$];
        int                retired;
        int                mismatches;
        int                status_seen [8];

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            foreach (status_seen[i]) status_seen[i] = 0;
            pc         = '0;
            zf         = 1'b0;
            sf         = 1'b0;
            sp         = STACK_DEPTH - 1;
            code_len   = '0;
            data_len   = '0;
            retired    = 0;
            mismatches = 0;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, int value);
            if (idx == CFG_CODE_LENGTH) code_len = CODE_W'(value);
            else data_len = DLEN_W'(value);
        endfunction

        function bit in_data(t_word a);
            return (a < t_word'(data_len)) && (a < t_word'(DATA_DEPTH));
        endfunction

        // Operand fetch; status is ok, bad operand or address out of range
        function logic [STATUS_W-1:0] fetch(input logic [MODE_W-1:0] mode, input t_word opnd,
                                            output t_kind kind, output t_word where,
                                            output t_word value);
            logic [STATUS_W-1:0] st;
            st    = ST_OK;
            kind  = K_NONE;
            where = '0;
            value = '0;
            case (mode)
                MODE_NONE: ;
                MODE_IMM: begin
                    kind  = K_IMM;
                    value = opnd;
                end
                MODE_REG: begin
                    if (opnd > REG_IDX_MAX) begin
                        st = ST_OPERAND;
                    end else begin
                        kind  = K_REG;
                        where = opnd;
                        value = gpr[opnd[1:0]];
                    end
                end
                MODE_DIR, MODE_IND: begin
                    if (mode == MODE_IND && opnd > REG_IDX_MAX) begin
                        st = ST_OPERAND;
                    end else begin
                        where = (mode == MODE_DIR) ? opnd : gpr[opnd[1:0]];
                        if (!in_data(where)) begin
                            st = ST_ADDRESS;
                        end else begin
                            kind  = K_MEM;
                            value = dmem[where[DATA_AW-1:0]];
                        end
                    end
                end
                default: st = ST_OPERAND;
            endcase
            return st;
        endfunction

        // Immediate destinations swallow the write
        function void store(t_kind kind, t_word where, t_word value);
            if (kind == K_REG) gpr[where[1:0]] = value;
            else if (kind == K_MEM) dmem[where[DATA_AW-1:0]] = value;
        endfunction

        // Execute one accepted instruction and queue its outcome
        function void note_issue(t_item it);
            t_kind               dk;
            t_kind               sk;
            t_word               dw;
            t_word               sw;
            t_word               dval;
            t_word               sval;
            t_word               res;
            t_word               nip;
            t_word               wv;
            logic [STATUS_W-1:0] st;
            retire_t             o;
            st  = ST_OK;
            wv  = '0;
            nip = pc + 1;
            if (it.cmd == CMD_LOAD) begin
                nip = pc;
                if (in_data({1'b0, it.dop})) begin
                    dmem[it.dop[DATA_AW-1:0]] = it.sop;
                    wv = it.sop;
                end else begin
                    st = ST_ADDRESS;
                end
            end else if (it.cmd > CMD_LOAD) begin
                st = ST_UNKNOWN;
            end else begin
                st = fetch(it.dmode, {1'b0, it.dop}, dk, dw, dval);
                if (st == ST_OK) st = fetch(it.smode, it.sop, sk, sw, sval);
                if (st == ST_OK) begin
                    case (it.cmd)
                        CMD_MOV, CMD_ADD: begin
                            if (dk == K_NONE || sk == K_NONE) begin
                                st = ST_OPERAND;
                            end else begin
                                res = (it.cmd == CMD_ADD) ? dval + sval : sval;
                                store(dk, dw, res);
                                wv = res;
                            end
                        end
                        CMD_CMP: begin
                            if (dk == K_NONE || sk == K_NONE) begin
                                st = ST_OPERAND;
                            end else begin
                                res = dval - sval;
                                zf  = (res == '0);
                                sf  = res[WORD_W-1];
                            end
                        end
                        CMD_JMP, CMD_JZ, CMD_JNZ: begin
                            if (dk == K_NONE) st = ST_OPERAND;
                            else if (it.cmd == CMD_JMP || (it.cmd == CMD_JZ && zf) ||
                                     (it.cmd == CMD_JNZ && !zf)) nip = dval;
                        end
                        CMD_HALT: nip = t_word'(code_len);
                        CMD_PUSH: begin
                            res = (sk != K_NONE) ? sval : gpr[0];
                            if (sp < 0) begin
                                st = ST_OVERFLOW;
                            end else begin
                                stk[sp] = res;
                                sp--;
                                wv = res;
                            end
                        end
                        default: begin
                            // POP; without a destination it lands in AX
                            if (sp >= STACK_DEPTH - 1) begin
                                st = ST_UNDERFLOW;
                            end else begin
                                sp++;
                                res = stk[sp];
                                if (dk != K_NONE) store(dk, dw, res);
                                else gpr[0] = res;
                                wv = res;
                            end
                        end
                    endcase
                end
            end
            pc = nip;
            o.status  = st;
            o.next_ip = nip;
            o.zf      = zf;
            o.sf      = sf;
            o.wv      = (st == ST_OK) ? wv : '0;
            outcomes_due.push_back(o);
        endfunction

        task report(string msg);
            if (mismatches < MAX_PRINTED) $display("%0t ns: %s", $time, msg);
            mismatches++;
        endtask

        // Compare one result transaction against the oldest outcome due
        task check_retire(retire_t got);
            retire_t want;
            if (outcomes_due.size() == 0) begin
                report($sformatf("result with no instruction outstanding (next_ip %h)",
                                 got.next_ip));
            end else begin
                want = outcomes_due.pop_front();
                retired++;
                status_seen[want.status]++;
                if (got.status !== want.status)
                    report($sformatf("result %0d status %0d, expected %0d",
                                     retired, got.status, want.status));
                if (got.next_ip !== want.next_ip)
                    report($sformatf("result %0d next_ip %h, expected %h",
                                     retired, got.next_ip, want.next_ip));
                if (got.zf !== want.zf)
                    report($sformatf("result %0d zero flag %b, expected %b",
                                     retired, got.zf, want.zf));
                if (got.sf !== want.sf)
                    report($sformatf("result %0d sign flag %b, expected %b",
                                     retired, got.sf, want.sf));
                if (got.wv !== want.wv)
                    report($sformatf("result %0d written value %h, expected %h",
                                     retired, got.wv, want.wv));
            end
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    bit                   running = 1'b0;
    bit                   tx_steady = 1'b0;
    bit                   rx_steady = 1'b0;
    int                   quiet = 0;
    int                   issued = 0;
    cpu_shadow            shadow;

    tce_cmd_if cmd_ch ();
    tce_res_if res_ch ();

    toy_cpu_execute_unit_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd_if    (cmd_ch),
        .o_res_if    (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: ends the run after a long stretch with no transaction
    always @(posedge clk) begin
        if (running) begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                quiet <= 0;
            end else begin
                quiet <= quiet + 1;
                if (quiet >= QUIET_LIMIT) begin
                    $display("no transaction for %0d cycles", QUIET_LIMIT);
                    $display("toy_cpu_execute_unit_core regression: fail");
                    $finish;
                end
            end
        end
    end

    // Result side: random stall per transaction, then check
    initial begin
        int      stall;
        retire_t got;
        wait (running);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 19);
            @(negedge clk);
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            got.status  = res_ch.status;
            got.next_ip = res_ch.next_ip;
            got.zf      = res_ch.zero_flag;
            got.sf      = res_ch.sign_flag;
            got.wv      = res_ch.written_value;
            shadow.check_retire(got);
        end
    end

    function automatic t_item instr(logic [CMD_W-1:0] cmd, logic [MODE_W-1:0] dmode,
                                    t_word dop, logic [MODE_W-1:0] smode, t_word sop);
        t_item it;
        it.cmd   = cmd;
        it.dmode = dmode;
        it.dop   = DOP_W'(dop);
        it.smode = smode;
        it.sop   = sop;
        return it;
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return MODE_W'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
        if (r < 14) return MODE_NONE;
        return MODE_W'($urandom_range(MODE_IMM, MODE_IND));
    endfunction

    // Operands mostly valid for their mode, with extremes and strays mixed in
    function automatic t_word pick_operand(logic [MODE_W-1:0] mode);
        int    r;
        t_word v;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_IMM: begin
                if (r < 45) v = $urandom_range(0, 255);
                else if (r < 75) v = $urandom;
                else begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h0000_0000;
                        1: v = 32'h7FFF_FFFF;
                        2: v = 32'h8000_0000;
                        default: v = 32'hFFFF_FFFF;
                    endcase
                end
            end
            MODE_REG, MODE_IND: v = (r < 92) ? $urandom_range(REG_AX, REG_DX) : $urandom;
            MODE_DIR: begin
                if (r < 85 && shadow.data_len != 0)
                    v = $urandom_range(0, int'(shadow.data_len) - 1);
                else if (r < 92) v = t_word'(shadow.data_len);
                else v = $urandom;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Random instruction; a non-negative argument fixes the command
    function automatic t_item random_instr(int fixed_cmd);
        t_item it;
        int    r;
        r = $urandom_range(0, 99);
        if (fixed_cmd >= 0) it.cmd = CMD_W'(fixed_cmd);
        else if (r < 4) it.cmd = CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
        else it.cmd = CMD_W'($urandom_range(CMD_MOV, CMD_LOAD));
        it.dmode = pick_mode();
        it.smode = pick_mode();
        // operands that are only resolved stay absent most of the time
        if (it.cmd == CMD_PUSH && $urandom_range(0, 3) != 0) it.dmode = MODE_NONE;
        if ((it.cmd == CMD_POP || it.cmd == CMD_JMP || it.cmd == CMD_JZ ||
             it.cmd == CMD_JNZ) && $urandom_range(0, 3) != 0) it.smode = MODE_NONE;
        if (it.cmd == CMD_HALT && $urandom_range(0, 3) != 0) begin
            it.dmode = MODE_NONE;
            it.smode = MODE_NONE;
        end
        it.dop = DOP_W'(pick_operand(it.dmode));
        it.sop = pick_operand(it.smode);
        if (it.cmd == CMD_LOAD) begin
            it.dmode = MODE_W'($urandom_range(MODE_NONE, MODE_BAD_HI));
            it.smode = MODE_W'($urandom_range(MODE_NONE, MODE_BAD_HI));
            it.dop   = DOP_W'(pick_operand(MODE_DIR));
            it.sop   = $urandom;
        end
        return it;
    endfunction

    // Drive one instruction transaction after a random gap
    task automatic send(input t_item it);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= it.cmd;
        cmd_ch.dest_mode    <= it.dmode;
        cmd_ch.dest_operand <= it.dop;
        cmd_ch.src_mode     <= it.smode;
        cmd_ch.src_operand  <= it.sop;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        shadow.note_issue(it);
        issued++;
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic wait_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (shadow.outcomes_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow.set_config(idx, value);
    endtask

    task automatic set_regs(input int code_len, input int data_len);
        wait_drained();
        write_cfg(CFG_CODE_LENGTH, code_len);
        write_cfg(CFG_DATA_LENGTH, data_len);
    endtask

    task automatic random_phase(input int code_len, input int data_len, input int count);
        set_regs(code_len, data_len);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < 2) wait_drained();
            send(random_instr(-1));
        end
    endtask

    initial begin
        shadow              = new();
        cmd_ch.valid        = 1'b0;
        cmd_ch.command      = '0;
        cmd_ch.dest_mode    = '0;
        cmd_ch.dest_operand = '0;
        cmd_ch.src_mode     = '0;
        cmd_ch.src_operand  = '0;
        res_ch.ready        = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n   <= 1'b1;
        running = 1'b1;

        // Fill the whole data store so later reads always hit written words
        write_cfg(CFG_CODE_LENGTH, 1024);
        write_cfg(CFG_DATA_LENGTH, DATA_DEPTH);
        for (int a = 0; a < DATA_DEPTH; a++)
            send(instr(CMD_LOAD, MODE_NONE, a, MODE_NONE,
                       ($urandom_range(0, 1) != 0) ? $urandom_range(0, 255) : $urandom));

        // Directed: arithmetic wrap, flags, jumps and pointer wrap
        send(instr(CMD_MOV, MODE_REG, REG_BX, MODE_IMM, 32'hFFFF_FFFF));
        send(instr(CMD_ADD, MODE_REG, REG_BX, MODE_IMM, 32'd2));
        send(instr(CMD_CMP, MODE_REG, REG_BX, MODE_IMM, 32'd1));
        send(instr(CMD_JZ, MODE_IMM, 32'h7FFF_FFFF, MODE_NONE, 32'd0));
        send(instr(CMD_MOV, MODE_REG, REG_CX, MODE_IMM, 32'hFFFF_FFFF));
        send(instr(CMD_JMP, MODE_REG, REG_CX, MODE_NONE, 32'd0));
        send(instr(CMD_MOV, MODE_REG, REG_DX, MODE_IMM, 32'd5));
        send(instr(CMD_CMP, MODE_IMM, 32'd0, MODE_IMM, 32'h8000_0000));
        send(instr(CMD_JNZ, MODE_IMM, 32'd40, MODE_NONE, 32'd0));
        send(instr(CMD_JZ, MODE_IMM, 32'd7, MODE_NONE, 32'd0));
        // immediate destination, indirect and direct memory operands
        send(instr(CMD_MOV, MODE_IMM, 32'd99, MODE_IMM, 32'd7));
        send(instr(CMD_MOV, MODE_IND, REG_DX, MODE_DIR, 32'd255));
        send(instr(CMD_ADD, MODE_DIR, 32'd5, MODE_REG, REG_DX));
        // error cases; destination is resolved before source
        send(instr(CMD_MOV, MODE_IND, REG_CX, MODE_IMM, 32'd1));
        send(instr(CMD_ADD, MODE_BAD_HI, 32'd0, MODE_DIR, 32'd999));
        send(instr(CMD_MOV, MODE_DIR, 32'h7FFF_FFFF, MODE_BAD_LO, 32'd0));
        send(instr(CMD_MOV, MODE_REG, REG_BAD, MODE_IMM, 32'd3));
        send(instr(CMD_ADD, MODE_NONE, 32'd0, MODE_IMM, 32'd3));
        send(instr(CMD_JMP, MODE_NONE, 32'd0, MODE_NONE, 32'd0));
        send(instr(CMD_JZ, MODE_IMM, 32'd3, MODE_REG, 32'd9));
        send(instr(CMD_UNKNOWN_HI, MODE_REG, REG_AX, MODE_IMM, 32'd1));
        // stack: implicit AX on push and pop, then underflow
        send(instr(CMD_PUSH, MODE_NONE, 32'd0, MODE_IMM, 32'h8000_0000));
        send(instr(CMD_POP, MODE_NONE, 32'd0, MODE_NONE, 32'd0));
        send(instr(CMD_PUSH, MODE_NONE, 32'd0, MODE_NONE, 32'd0));
        send(instr(CMD_POP, MODE_REG, REG_BX, MODE_NONE, 32'd0));
        send(instr(CMD_POP, MODE_NONE, 32'd0, MODE_NONE, 32'd0));
        send(instr(CMD_HALT, MODE_NONE, 32'd0, MODE_BAD_LO, 32'd0));
        send(instr(CMD_HALT, MODE_NONE, 32'd0, MODE_NONE, 32'd0));
        send(instr(CMD_LOAD, MODE_NONE, DATA_DEPTH, MODE_NONE, 32'd1));
        send(instr(CMD_LOAD, MODE_BAD_HI, DATA_DEPTH - 1, MODE_BAD_HI, 32'h7FFF_FFFF));

        // Empty code and data regions: every memory operand is out of range
        random_phase(0, 0, 40);

        // Fill the stack past overflow, then drain it past underflow
        set_regs($urandom_range(0, 1024), DATA_DEPTH);
        tx_steady = 1'b1;
        rx_steady = 1'b0;
        while (shadow.sp >= 0) send(random_instr(int'(CMD_PUSH)));
        repeat (3) send(random_instr(int'(CMD_PUSH)));
        tx_steady = 1'b0;
        rx_steady = 1'b1;
        while (shadow.sp < STACK_DEPTH - 1) send(random_instr(int'(CMD_POP)));
        repeat (3) send(random_instr(int'(CMD_POP)));

        random_phase($urandom_range(0, 1024), $urandom_range(1, DATA_DEPTH - 1), 130);
        random_phase(1, 1, 130);
        random_phase($urandom_range(0, 1024), $urandom_range(0, DATA_DEPTH), 130);
        random_phase(1024, DATA_DEPTH, 130);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d instructions issued, %0d results: ok %0d, bad operand %0d, range %0d",
                 issued, shadow.retired, shadow.status_seen[ST_OK],
                 shadow.status_seen[ST_OPERAND], shadow.status_seen[ST_ADDRESS]);
        $display("overflow %0d, underflow %0d, unknown command %0d, mismatches %0d",
                 shadow.status_seen[ST_OVERFLOW], shadow.status_seen[ST_UNDERFLOW],
                 shadow.status_seen[ST_UNKNOWN], shadow.mismatches);
        if (shadow.mismatches == 0) begin
            $display("toy_cpu_execute_unit_core regression: pass");
        end else begin
            $display("toy_cpu_execute_unit_core regression: fail");
        end
        $finish;
    end

endmodule
